// ----- hdl/sm3_pkg.sv -----
// Package for the SM3 hash engine: constants, state codes and round helper functions.
package sm3_pkg;

   localparam logic [31:0] SM3_IV [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   localparam logic [31:0] TJ_LOW   = 32'h79cc4519;
   localparam logic [31:0] TJ_HIGH  = 32'h7a879d8a;
   localparam logic [7:0]  PAD_MARK = 8'h80;
   localparam logic [5:0]  LEN_POS  = 6'd56;
   localparam logic [5:0]  LAST_POS = 6'd63;
   localparam logic [5:0]  LAST_RND = 6'd63;
   localparam logic [3:0]  LEN_BYTES = 4'd8;
   localparam logic [2:0]  MAX_BYTES = 3'd4;
   localparam logic [2:0]  LAST_OUT  = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ABSORB = 5'b00010,
      ST_PAD    = 5'b00100,
      ST_COMP   = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   function automatic logic [31:0] rol_var(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] dbl;
      dbl = {x, x} << n;
      return dbl[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
   endfunction

endpackage

// ----- hdl/sm3_hash_engine.sv -----
// SM3 digest engine: byte packer, message window and a single iterated round unit.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-------------------------------------
//  req     | in        | req_valid / req_ready | req_data_word, req_valid_bytes, req_last
//  rsp     | out       | rsp_valid / rsp_ready | rsp_digest_word, rsp_digest_last
//
// A word is accepted in the idle state; its valid bytes are then absorbed in turn before the word closes.
// Every full 64-byte block runs the 64 rounds of the shared round unit.
// A last word adds the padding bytes, one per cycle while no compression runs, and one or two compressions.
// Synchronous reset loads the initial value and clears the byte and bit counts.
// req_ready is high only in the idle state; digest beats wait for rsp_ready.
module sm3_hash_engine
   import sm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_digest_last
);

   state_type   state_ff, state_in;
   logic [31:0] cv_ff [8];
   logic [31:0] cv_in [8];
   logic [31:0] wk_ff [8];
   logic [31:0] wk_in [8];
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [63:0] bitlen_ff, bitlen_in;
   logic [5:0]  pos_ff, pos_in;
   logic [31:0] partial_ff, partial_in;
   logic [31:0] data_ff, data_in;
   logic [2:0]  rem_ff, rem_in;
   logic        last_ff, last_in;
   logic        mark_ff, mark_in;
   logic [3:0]  len_cnt_ff, len_cnt_in;
   logic        ret_pad_ff, ret_pad_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   logic        push_en;
   logic [7:0]  push_byte;
   logic [31:0] push_word;
   logic [31:0] part_new;

   // Round unit signals.
   logic [31:0] a12, tj_rot, ss1, ss2, ff_v, gg_v, tt1, tt2, exp_x, exp_w;
   logic        early;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = cv_ff[0];
   assign rsp_digest_last = (out_idx_ff == LAST_OUT);

   always_comb begin
      early  = (rnd_ff[5:4] == 2'b00);
      tj_rot = rol_var(early ? TJ_LOW : TJ_HIGH, rnd_ff[4:0]);
      a12    = {wk_ff[0][19:0], wk_ff[0][31:20]};
      ss1    = a12 + wk_ff[4] + tj_rot;
      ss1    = {ss1[24:0], ss1[31:25]};
      ss2    = ss1 ^ a12;
      if (early) begin
         ff_v = wk_ff[0] ^ wk_ff[1] ^ wk_ff[2];
         gg_v = wk_ff[4] ^ wk_ff[5] ^ wk_ff[6];
      end else begin
         ff_v = (wk_ff[0] & wk_ff[1]) | (wk_ff[0] & wk_ff[2]) | (wk_ff[1] & wk_ff[2]);
         gg_v = (wk_ff[4] & wk_ff[5]) | (~wk_ff[4] & wk_ff[6]);
      end
      tt1   = ff_v + wk_ff[3] + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2   = gg_v + wk_ff[7] + ss1 + win_ff[0];
      exp_x = win_ff[0] ^ win_ff[7] ^ {win_ff[13][16:0], win_ff[13][31:17]};
      exp_w = perm1(exp_x) ^ {win_ff[3][24:0], win_ff[3][31:25]} ^ win_ff[10];
   end

   always_comb begin
      state_in   = state_ff;
      cv_in      = cv_ff;
      wk_in      = wk_ff;
      win_in     = win_ff;
      bitlen_in  = bitlen_ff;
      pos_in     = pos_ff;
      partial_in = partial_ff;
      data_in    = data_ff;
      rem_in     = rem_ff;
      last_in    = last_ff;
      mark_in    = mark_ff;
      len_cnt_in = len_cnt_ff;
      ret_pad_in = ret_pad_ff;
      rnd_in     = rnd_ff;
      out_idx_in = out_idx_ff;
      push_en    = 1'b0;
      push_byte  = 8'h00;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               data_in  = req_data_word;
               rem_in   = (req_valid_bytes > MAX_BYTES) ? MAX_BYTES : req_valid_bytes;
               last_in  = req_last;
               state_in = ST_ABSORB;
            end
         end
         ST_ABSORB: begin
            if (rem_ff != 3'd0) begin
               push_en    = 1'b1;
               push_byte  = data_ff[31:24];
               data_in    = {data_ff[23:0], 8'h00};
               rem_in     = rem_ff - 3'd1;
               bitlen_in  = bitlen_ff + 64'd8;
               ret_pad_in = 1'b0;
            end else if (last_ff) begin
               mark_in    = 1'b0;
               len_cnt_in = 4'd0;
               state_in   = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            push_en    = 1'b1;
            ret_pad_in = 1'b1;
            if (!mark_ff) begin
               push_byte = PAD_MARK;
               mark_in   = 1'b1;
            end else if ((len_cnt_ff != 4'd0) || (pos_ff == LEN_POS)) begin
               // The length goes out most significant byte first, so it is shifted away.
               push_byte  = bitlen_ff[63:56];
               bitlen_in  = {bitlen_ff[55:0], 8'h00};
               len_cnt_in = len_cnt_ff + 4'd1;
            end
         end
         ST_COMP: begin
            wk_in[0] = tt1;
            wk_in[1] = wk_ff[0];
            wk_in[2] = {wk_ff[1][22:0], wk_ff[1][31:23]};
            wk_in[3] = wk_ff[2];
            wk_in[4] = perm0(tt2);
            wk_in[5] = wk_ff[4];
            wk_in[6] = {wk_ff[5][12:0], wk_ff[5][31:13]};
            wk_in[7] = wk_ff[6];
            for (int k = 0; k < 15; k++) begin
               win_in[k] = win_ff[k + 1];
            end
            win_in[15] = exp_w;
            rnd_in     = rnd_ff + 6'd1;
            if (rnd_ff == LAST_RND) begin
               for (int k = 0; k < 8; k++) begin
                  cv_in[k] = cv_ff[k] ^ wk_in[k];
               end
               if (!ret_pad_ff) begin
                  state_in = ST_ABSORB;
               end else if (len_cnt_ff == LEN_BYTES) begin
                  out_idx_in = 3'd0;
                  state_in   = ST_OUT;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               for (int k = 0; k < 7; k++) begin
                  cv_in[k] = cv_ff[k + 1];
               end
               cv_in[7]   = cv_ff[0];
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == LAST_OUT) begin
                  cv_in      = SM3_IV;
                  bitlen_in  = 64'd0;
                  pos_in     = 6'd0;
                  partial_in = 32'd0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Byte packer: a completed word shifts into the top of the message window.
      push_word = {push_byte, 24'h000000} >> {pos_ff[1:0], 3'b000};
      part_new  = (pos_ff[1:0] == 2'd0) ? push_word : (partial_ff | push_word);
      if (push_en) begin
         partial_in = part_new;
         pos_in     = pos_ff + 6'd1;
         if (pos_ff[1:0] == 2'd3) begin
            for (int k = 0; k < 15; k++) begin
               win_in[k] = win_ff[k + 1];
            end
            win_in[15] = part_new;
         end
         if (pos_ff == LAST_POS) begin
            wk_in    = cv_ff;
            rnd_in   = 6'd0;
            state_in = ST_COMP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cv_ff      <= SM3_IV;
         bitlen_ff  <= 64'd0;
         pos_ff     <= 6'd0;
         partial_ff <= 32'd0;
         rem_ff     <= 3'd0;
         last_ff    <= 1'b0;
         mark_ff    <= 1'b0;
         len_cnt_ff <= 4'd0;
         ret_pad_ff <= 1'b0;
         rnd_ff     <= 6'd0;
         out_idx_ff <= 3'd0;
      end else begin
         state_ff   <= state_in;
         cv_ff      <= cv_in;
         bitlen_ff  <= bitlen_in;
         pos_ff     <= pos_in;
         partial_ff <= partial_in;
         rem_ff     <= rem_in;
         last_ff    <= last_in;
         mark_ff    <= mark_in;
         len_cnt_ff <= len_cnt_in;
         ret_pad_ff <= ret_pad_in;
         rnd_ff     <= rnd_in;
         out_idx_ff <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      wk_ff   <= wk_in;
      win_ff  <= win_in;
      data_ff <= data_in;
   end

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the SM3 hash engine, with a digest predictor and random stimulus.
`timescale 1ns / 1ps

module tb;

   localparam logic [31:0] IV_WORDS [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };
   localparam logic [31:0] T_EARLY    = 32'h79cc4519;
   localparam logic [31:0] T_LATE     = 32'h7a879d8a;
   localparam logic [7:0]  MARK_BYTE  = 8'h80;
   localparam logic [5:0]  LENGTH_POS = 6'd56;
   localparam int          ITEM_GOAL  = 350;

   // Tracks the expected digest of the message in flight and checks every digest beat.
   class sm3_digest_tracker;
      logic [31:0] chain [8];
      logic [31:0] block [16];
      logic [31:0] packing;
      logic [63:0] bit_count;
      logic [32:0] expected_digest [$];
      int          errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         foreach (chain[i]) chain[i] = IV_WORDS[i];
         packing   = '0;
         bit_count = '0;
      endfunction

      function logic [31:0] rotl(logic [31:0] x, int n);
         n = n % 32;
         return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
      endfunction

      function logic [31:0] mix0(logic [31:0] x);
         return x ^ rotl(x, 9) ^ rotl(x, 17);
      endfunction

      function logic [31:0] mix1(logic [31:0] x);
         return x ^ rotl(x, 15) ^ rotl(x, 23);
      endfunction

      function void compress();
         logic [31:0] w [68];
         logic [31:0] a, b, c, d, e, f, g, h;
         logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
         int          j;
         for (j = 0; j < 16; j++) w[j] = block[j];
         for (j = 16; j < 68; j++)
            w[j] = mix1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
         e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
         for (j = 0; j < 64; j++) begin
            tj  = (j < 16) ? T_EARLY : T_LATE;
            a12 = rotl(a, 12);
            ss1 = rotl(a12 + e + rotl(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
               ff = a ^ b ^ c;
               gg = e ^ f ^ g;
            end else begin
               ff = (a & b) | (a & c) | (b & c);
               gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rotl(b, 9); b = a; a = tt1;
            h = g; g = rotl(f, 19); f = e; e = mix0(tt2);
         end
         chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
         chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
      endfunction

      function void place_byte(logic [7:0] value, logic [5:0] pos);
         logic [31:0] shifted;
         int          lane;
         lane    = pos[1:0];
         shifted = {24'h0, value} << (8 * (3 - lane));
         packing = (lane == 0) ? shifted : (packing | shifted);
         if (lane == 3) begin
            block[pos[5:2]] = packing;
            if (pos == 6'd63) compress();
         end
      endfunction

      // Called for every accepted input beat; a closing word queues the eight digest words.
      function void absorb_word(logic [31:0] data, logic [2:0] nbytes, logic fin);
         int          count;
         logic [5:0]  pos;
         logic [63:0] total;
         count = (nbytes > 3'd4) ? 4 : nbytes;
         for (int i = 0; i < count; i++) begin
            place_byte(data[31-8*i -: 8], bit_count[8:3]);
            bit_count += 64'd8;
         end
         if (!fin) return;
         total = bit_count;
         pos   = total[8:3];
         place_byte(MARK_BYTE, pos);
         pos++;
         while (pos != LENGTH_POS) begin
            place_byte(8'h00, pos);
            pos++;
         end
         for (int i = 0; i < 8; i++) begin
            place_byte(total[63-8*i -: 8], pos);
            pos++;
         end
         for (int i = 0; i < 8; i++) expected_digest.push_back({i == 7, chain[i]});
         restart();
      endfunction

      function void check_digest_beat(logic [31:0] word, logic fin);
         logic [32:0] want;
         if (expected_digest.size() == 0) begin
            $display("%0t: unexpected digest beat %h last %b", $time, word, fin);
            errors++;
            return;
         end
         want = expected_digest.pop_front();
         if (want[31:0] !== word) begin
            $display("%0t: digest word mismatch: expected %h, actual %h", $time, want[31:0], word);
            errors++;
         end
         if (want[32] !== fin) begin
            $display("%0t: digest last mismatch: expected %b, actual %b", $time, want[32], fin);
            errors++;
         end
      endfunction

      function int pending();
         return expected_digest.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_data_word;
   logic [2:0]  req_valid_bytes;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic        rsp_digest_last;

   sm3_digest_tracker tracker;
   int                req_idle_pct;
   int                rsp_idle_pct;
   int                sent_items;

   sm3_hash_engine DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_digest_last (rsp_digest_last)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial rsp_ready = 1'b0;
   always @(negedge clock) begin
      rsp_ready = !reset && ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.absorb_word(req_data_word, req_valid_bytes, req_last);
         if (rsp_valid && rsp_ready)
            tracker.check_digest_beat(rsp_digest_word, rsp_digest_last);
      end
   end

   // Entered just after a falling edge; leaves valid high so that beats can follow back to back.
   task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes, input logic fin);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_data_word   = data;
      req_valid_bytes = nbytes;
      req_last        = fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (nbytes != 3'd0 || fin) sent_items++;
   endtask

   // Mostly full words; the last word and now and then a middle word get a random count, short or over-long.
   task automatic send_message(input int nwords);
      logic [2:0] nbytes;
      logic       fin;
      for (int k = 0; k < nwords; k++) begin
         fin = (k == nwords - 1);
         if (fin || $urandom_range(9) == 0) nbytes = 3'($urandom_range(7));
         else nbytes = 3'd4;
         send_word($urandom, nbytes, fin);
      end
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   task automatic random_phase(input int goal);
      while (sent_items < goal) begin
         if ($urandom_range(4) == 0) send_message($urandom_range(21, 40));
         else send_message($urandom_range(1, 20));
      end
      drain();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_word   = '0;
      req_valid_bytes = '0;
      req_last        = 1'b0;
      req_idle_pct    = 0;
      rsp_idle_pct    = 0;
      sent_items      = 0;
      tracker         = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty message with junk data, then "abc" with a junk trailing byte.
      send_word(32'hffffffff, 3'd0, 1'b1);
      send_word(32'h616263ff, 3'd3, 1'b1);
      // Short words without last keep the stream byte aligned; an empty word adds nothing.
      send_word(32'ha5ffffff, 3'd1, 1'b0);
      send_word(32'h12345678, 3'd0, 1'b0);
      send_word(32'hdeadbeef, 3'd2, 1'b0);
      send_word(32'h00000000, 3'd7, 1'b1);
      // Fifty-six bytes, so the length no longer fits and a second padding block is needed.
      // Counts of five and six saturate to a full word.
      for (int k = 0; k < 14; k++)
         send_word((k % 2) ? 32'h00000000 : 32'hffffffff,
                   (k == 3) ? 3'd5 : (k == 8) ? 3'd6 : 3'd4, k == 13);
      drain();

      req_idle_pct = 11;
      rsp_idle_pct = 81;
      random_phase(sent_items + ITEM_GOAL / 3);
      req_idle_pct = 81;
      rsp_idle_pct = 11;
      random_phase(sent_items + ITEM_GOAL / 3);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_phase(sent_items + ITEM_GOAL / 3);

      // A closing word runs up to two compressions plus padding before its digest appears.
      repeat (300) @(negedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d digest words outstanding", tracker.pending());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/sm3_pkg.sv
hdl/sm3_hash_engine.sv
test/tb.sv
